// ----- rtl/mipid_pkg.sv -----
package mipid_pkg;

   // Field widths of the channels and registers
   localparam int CHAN_W     = 3;
   localparam int VALUE_W    = 16;
   localparam int GAIN_W     = 32;
   localparam int LIMIT_W    = 15;
   localparam int DAC_W      = 16;
   localparam int OLG_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Datapath widths
   localparam int FRAC_W   = 16;                 // Q.16 fraction of drive values
   localparam int ERR_W    = VALUE_W + 1;        // target minus measurement
   localparam int MULA_W   = GAIN_W + 1;         // gain or zero-extended open-loop factor
   localparam int PROD0_W  = MULA_W + ERR_W;
   localparam int PROD_W   = GAIN_W + ERR_W;
   localparam int SUM_W    = PROD0_W + 2;        // three products plus held drive
   localparam int DRIVE_W  = 32;                 // saturated drive always fits here

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_PID    = 2'd0,   // closed-loop sample: update drive and error history
      KIND_LOAD   = 2'd1,   // open-loop target: scale straight into drive
      KIND_TARGET = 2'd2,   // closed-loop target within limit: store it
      KIND_HOLD   = 2'd3    // report held code only
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_NOW       = 3'd0,
      CSR_GAIN_PREV      = 3'd1,
      CSR_GAIN_PREV2     = 3'd2,
      CSR_OUTPUT_LIMIT   = 3'd3,
      CSR_TARGET_LIMIT   = 3'd4,
      CSR_DAC_ZERO       = 3'd5,
      CSR_OPEN_LOOP      = 3'd6,
      CSR_OPEN_LOOP_GAIN = 3'd7
   } csr_index_type;

   typedef struct packed {
      kind_type                   kind;
      logic                       rejected;
      logic [CHAN_W-1:0]          channel;
      logic signed [VALUE_W-1:0]  value;
   } item_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_now;
      logic signed [GAIN_W-1:0] gain_prev;
      logic signed [GAIN_W-1:0] gain_prev2;
      logic [LIMIT_W-1:0]       output_limit;
      logic [LIMIT_W-1:0]       target_limit;
      logic [DAC_W-1:0]         dac_zero;
      logic                     open_loop;
      logic [OLG_W-1:0]         open_loop_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_now:       '0,
      gain_prev:      '0,
      gain_prev2:     '0,
      output_limit:   15'd32767,
      target_limit:   15'd32767,
      dac_zero:       16'd32768,
      open_loop:      1'b0,
      open_loop_gain: 24'd65536
   };

endpackage

// ----- rtl/mipid_front.sv -----
module mipid_front
   import mipid_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [CHAN_W-1:0]         req_channel,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      open_loop,
   input  logic [LIMIT_W-1:0]        target_limit,
   input  logic                      queue_full,
   output logic                      item_valid,
   output item_type                  item
);

   logic      valid_ff, valid_in;
   item_type  item_ff, item_in, classified;
   logic      load, push, in_range, too_big;
   logic [VALUE_W-1:0] magnitude;

   assign req_stall = valid_ff & queue_full;
   assign load      = req_valid & ~req_stall;
   assign push      = valid_ff & ~queue_full;
   assign in_range  = {{(32-CHAN_W){1'b0}}, req_channel} < CHANNELS;

   // The magnitude of -32768 still fits sixteen unsigned bits
   assign magnitude = req_value[VALUE_W-1] ? VALUE_W'(-req_value) : VALUE_W'(req_value);
   assign too_big   = magnitude > {1'b0, target_limit};

   always_comb begin
      classified.channel  = req_channel;
      classified.value    = req_value;
      classified.rejected = 1'b0;
      if (!req_action) begin
         classified.kind = open_loop ? KIND_HOLD : KIND_PID;
      end else if (open_loop) begin
         classified.kind = KIND_LOAD;
      end else if (too_big) begin
         classified.kind     = KIND_HOLD;
         classified.rejected = 1'b1;
      end else begin
         classified.kind = KIND_TARGET;
      end
   end

   // Drop items for channels that do not exist
   assign valid_in = (load & in_range) | (valid_ff & ~push);
   assign item_in  = load ? classified : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- rtl/mipid_queue.sv -----
module mipid_queue
   import mipid_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  item_type  push_item,
   output logic      full,
   input  logic      pop,
   output logic      pop_valid,
   output item_type  pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~full;
   assign do_pop    = pop & pop_valid;

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/mipid_back.sv -----
module mipid_back
   import mipid_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               head_valid,
   input  item_type           head_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAN_W-1:0]  rsp_channel_res,
   output logic [DAC_W-1:0]   rsp_dac_code,
   output logic               rsp_target_rejected
);

   // Channel codes above the field range can never arrive
   localparam int NCH   = (CHANNELS < (1 << CHAN_W)) ? CHANNELS : (1 << CHAN_W);
   localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;

   localparam logic signed [SUM_W-1:0] ONE_COUNT =
      {{(SUM_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};
   localparam logic [DRIVE_W-1:0] TRUNC_BIAS =
      {{(DRIVE_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}};

   // Per-channel state
   logic signed [VALUE_W-1:0] target_ff [NCH];
   logic signed [ERR_W-1:0]   err1_ff   [NCH];
   logic signed [ERR_W-1:0]   err2_ff   [NCH];
   logic signed [DRIVE_W-1:0] drive_ff  [NCH];

   logic adv;

   // Stage A: state read, error, multiplies
   logic [IDX_W-1:0]          a_idx;
   logic signed [ERR_W-1:0]   a_err0;
   logic signed [MULA_W-1:0]  a_mul_a;
   logic signed [ERR_W-1:0]   a_mul_b;
   logic signed [PROD0_W-1:0] a_p0;
   logic signed [PROD_W-1:0]  a_p1, a_p2;

   logic                      s1_valid_ff, s1_valid_in;
   kind_type                  s1_kind_ff;
   logic                      s1_rej_ff;
   logic [CHAN_W-1:0]         s1_chan_ff;
   logic signed [PROD0_W-1:0] s1_p0_ff;
   logic signed [PROD_W-1:0]  s1_p1_ff, s1_p2_ff;

   // Stage B: sum of products
   logic signed [SUM_W-1:0]   b_p0, b_p1, b_p2, b_sum;

   logic                      s2_valid_ff, s2_valid_in;
   kind_type                  s2_kind_ff;
   logic                      s2_rej_ff;
   logic [CHAN_W-1:0]         s2_chan_ff;
   logic signed [SUM_W-1:0]   s2_sum_ff;

   // Stage C: accumulate and saturate
   logic [IDX_W-1:0]          c_idx;
   logic signed [SUM_W-1:0]   c_old, c_u, c_lim, c_floor, c_clamp, c_guard;
   logic signed [DRIVE_W-1:0] c_new;
   logic                      c_update;

   logic                      s3_valid_ff, s3_valid_in;
   logic                      s3_rej_ff;
   logic [CHAN_W-1:0]         s3_chan_ff;
   logic signed [DRIVE_W-1:0] s3_drive_ff;

   // Output register
   logic [DRIVE_W-1:0]        d_biased;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]         rsp_chan_ff;
   logic [DAC_W-1:0]          rsp_code_ff;
   logic                      rsp_rej_ff;

   assign adv = ~rsp_valid_ff | ~rsp_stall;
   assign pop = adv & head_valid;

   // ---- stage A
   assign a_idx  = head_item.channel[IDX_W-1:0];
   assign a_err0 = ERR_W'(target_ff[a_idx]) - ERR_W'(head_item.value);

   always_comb begin
      if (head_item.kind == KIND_LOAD) begin
         a_mul_a = $signed({{(MULA_W-OLG_W){1'b0}}, cfg.open_loop_gain});
         a_mul_b = ERR_W'(head_item.value);
      end else begin
         a_mul_a = MULA_W'(cfg.gain_now);
         a_mul_b = a_err0;
      end
   end

   assign a_p0 = PROD0_W'(a_mul_a) * PROD0_W'(a_mul_b);
   assign a_p1 = PROD_W'(cfg.gain_prev)  * PROD_W'(err1_ff[a_idx]);
   assign a_p2 = PROD_W'(cfg.gain_prev2) * PROD_W'(err2_ff[a_idx]);

   assign s1_valid_in = adv ? head_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCH; i++) begin
            target_ff[i] <= '0;
            err1_ff[i]   <= '0;
            err2_ff[i]   <= '0;
         end
      end else if (pop) begin
         unique case (head_item.kind)
            KIND_PID: begin
               err2_ff[a_idx] <= err1_ff[a_idx];
               err1_ff[a_idx] <= a_err0;
            end
            KIND_TARGET: begin
               target_ff[a_idx] <= head_item.value;
            end
            KIND_LOAD, KIND_HOLD: begin
            end
         endcase
      end
   end

   // ---- stage B
   assign b_p0  = SUM_W'(s1_p0_ff);
   assign b_p1  = (s1_kind_ff == KIND_PID) ? SUM_W'(s1_p1_ff) : '0;
   assign b_p2  = (s1_kind_ff == KIND_PID) ? SUM_W'(s1_p2_ff) : '0;
   assign b_sum = b_p0 + b_p1 + b_p2;

   assign s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

   // ---- stage C
   assign c_idx    = s2_chan_ff[IDX_W-1:0];
   assign c_old    = SUM_W'(drive_ff[c_idx]);
   assign c_u      = ((s2_kind_ff == KIND_PID) ? c_old : '0) + s2_sum_ff;
   assign c_lim    = $signed({{(SUM_W-LIMIT_W-FRAC_W){1'b0}}, cfg.output_limit,
                              {FRAC_W{1'b0}}});
   assign c_floor  = -$signed({{(SUM_W-DAC_W-FRAC_W){1'b0}}, cfg.dac_zero,
                               {FRAC_W{1'b0}}});
   assign c_update = (s2_kind_ff == KIND_PID) | (s2_kind_ff == KIND_LOAD);

   always_comb begin
      priority if (c_u < -c_lim) begin
         c_clamp = -c_lim;
      end else if (c_u > c_lim) begin
         c_clamp = c_lim;
      end else begin
         c_clamp = c_u;
      end
   end

   // Keep the drive one count clear of the code that would wrap below zero
   assign c_guard = (c_clamp <= c_floor) ? c_floor + ONE_COUNT : c_clamp;
   assign c_new   = c_update ? c_guard[DRIVE_W-1:0] : c_old[DRIVE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCH; i++) begin
            drive_ff[i] <= '0;
         end
      end else if (adv & s2_valid_ff & c_update) begin
         drive_ff[c_idx] <= c_new;
      end
   end

   assign s3_valid_in = adv ? s2_valid_ff : s3_valid_ff;

   // ---- output: truncate toward zero, then offset
   assign d_biased = s3_drive_ff[DRIVE_W-1] ? DRIVE_W'(s3_drive_ff) + TRUNC_BIAS
                                             : DRIVE_W'(s3_drive_ff);
   assign rsp_valid_in = adv ? s3_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff  <= head_item.kind;
         s1_rej_ff   <= head_item.rejected;
         s1_chan_ff  <= head_item.channel;
         s1_p0_ff    <= a_p0;
         s1_p1_ff    <= a_p1;
         s1_p2_ff    <= a_p2;
         s2_kind_ff  <= s1_kind_ff;
         s2_rej_ff   <= s1_rej_ff;
         s2_chan_ff  <= s1_chan_ff;
         s2_sum_ff   <= b_sum;
         s3_rej_ff   <= s2_rej_ff;
         s3_chan_ff  <= s2_chan_ff;
         s3_drive_ff <= c_new;
         rsp_chan_ff <= s3_chan_ff;
         rsp_rej_ff  <= s3_rej_ff;
         rsp_code_ff <= d_biased[FRAC_W +: DAC_W] + cfg.dac_zero;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_channel_res     = rsp_chan_ff;
   assign rsp_dac_code        = rsp_code_ff;
   assign rsp_target_rejected = rsp_rej_ff;

endmodule

// ----- rtl/multichannel_incremental_pid.sv -----
// Path: front register, queue, back stages A, B and C, then the output register.
// Throughput: one item per cycle (no stall), set by the single-issue back pipeline;
//   the per-channel history is written in the multiply stage and the drive in the
//   saturate stage, so items for the same channel follow each other freely.
// Reset: synchronous, active high; clears all channel state and the queue and
//   loads the register defaults. No clearing pass, ready the cycle after reset.
module multichannel_incremental_pid
   import mipid_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic [CHAN_W-1:0]           req_channel,
   input  logic signed [VALUE_W-1:0]   req_value,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [CHAN_W-1:0]           rsp_channel_res,
   output logic [DAC_W-1:0]            rsp_dac_code,
   output logic                        rsp_target_rejected,
   // register write port
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data
);

   cfg_type   cfg_ff, cfg_in;
   logic      front_valid, queue_full, head_valid, pop;
   item_type  front_item, head_item;

   // Register file: take a write whenever the enable is high
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN_NOW:       cfg_in.gain_now       = $signed(csr_data[GAIN_W-1:0]);
            CSR_GAIN_PREV:      cfg_in.gain_prev      = $signed(csr_data[GAIN_W-1:0]);
            CSR_GAIN_PREV2:     cfg_in.gain_prev2     = $signed(csr_data[GAIN_W-1:0]);
            CSR_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_data[LIMIT_W-1:0];
            CSR_TARGET_LIMIT:   cfg_in.target_limit   = csr_data[LIMIT_W-1:0];
            CSR_DAC_ZERO:       cfg_in.dac_zero       = csr_data[DAC_W-1:0];
            CSR_OPEN_LOOP:      cfg_in.open_loop      = csr_data[0];
            CSR_OPEN_LOOP_GAIN: cfg_in.open_loop_gain = csr_data[OLG_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: register each transfer, classify it and drop unknown channels
   mipid_front #(
      .CHANNELS     (CHANNELS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_channel  (req_channel),
      .req_value    (req_value),
      .open_loop    (cfg_ff.open_loop),
      .target_limit (cfg_ff.target_limit),
      .queue_full   (queue_full),
      .item_valid   (front_valid),
      .item         (front_item)
   );

   // Short queue: lets the front keep taking transfers while results stall
   mipid_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (head_valid),
      .pop_item   (head_item)
   );

   // Back: multiply, accumulate, saturate and form the DAC code; the whole
   // pipeline advances only while the output register can move on
   mipid_back #(
      .CHANNELS            (CHANNELS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .head_valid          (head_valid),
      .head_item           (head_item),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_channel_res     (rsp_channel_res),
      .rsp_dac_code        (rsp_dac_code),
      .rsp_target_rejected (rsp_target_rejected)
   );

endmodule

// ----- tb/mipid_tb_pkg.sv -----
package mipid_tb_pkg;

   import mipid_pkg::*;

   localparam int NUM_CH = 8;

   typedef enum logic {
      ACT_SAMPLE = 1'b0,
      ACT_TARGET = 1'b1
   } action_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [DAC_W-1:0]  dac_code;
      logic              rejected;
   } pid_result_type;

endpackage

// ----- tb/mipid_checker.sv -----
module mipid_checker
   import mipid_pkg::*;
   import mipid_tb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_action,
   input  logic [CHAN_W-1:0]         req_channel,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [CHAN_W-1:0]         rsp_channel_res,
   input  logic [DAC_W-1:0]          rsp_dac_code,
   input  logic                      rsp_target_rejected,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   output int                        mismatch_count,
   output int                        pending_count,
   output int                        results_checked,
   output int                        rejects_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow of the register file
   logic signed [GAIN_W-1:0] gain_now_q, gain_prev_q, gain_prev2_q;
   logic [LIMIT_W-1:0]       out_limit_q, tgt_limit_q;
   logic [DAC_W-1:0]         dac_zero_q;
   logic                     open_loop_q;
   logic [OLG_W-1:0]         ol_gain_q;

   // per-channel controller state
   logic signed [VALUE_W-1:0] target_mem [NUM_CH];
   logic signed [ERR_W-1:0]   err_last   [NUM_CH];
   logic signed [ERR_W-1:0]   err_older  [NUM_CH];
   logic signed [39:0]        drive_mem  [NUM_CH];

   pid_result_type dac_expect_q [$];
   pid_result_type oldest;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("%0t ns mismatch: %s, got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // clamp to the output limit, then keep one count above negative zero-code
   function automatic longint clamp_drive(input longint u);
      longint lim, flo;
      lim = out_limit_q;
      lim = lim * 65536;
      flo = dac_zero_q;
      flo = -flo * 65536;
      if (u < -lim) u = -lim;
      else if (u > lim) u = lim;
      if (u <= flo) u = flo + 65536;
      return u;
   endfunction

   function automatic logic [DAC_W-1:0] code_of(input longint u);
      longint whole, zero;
      zero = dac_zero_q;
      if (u < 0) whole = -((-u) >>> FRAC_W);
      else whole = u >>> FRAC_W;
      return DAC_W'(whole + zero);
   endfunction

   task automatic predict_pid_step(input logic act, input logic [CHAN_W-1:0] ch,
                                   input logic signed [VALUE_W-1:0] val);
      longint v, e0, e1, e2, acc, mag, lim, g0, g1, g2, k;
      pid_result_type r;
      v = val;
      r.rejected = 1'b0;
      if (act == ACT_TARGET) begin
         if (open_loop_q) begin
            k = ol_gain_q;
            drive_mem[ch] = 40'(clamp_drive(v * k));
         end else begin
            mag = (v < 0) ? -v : v;
            lim = tgt_limit_q;
            if (mag > lim) r.rejected = 1'b1;
            else target_mem[ch] = val;
         end
      end else if (!open_loop_q) begin
         acc = target_mem[ch];
         e0  = acc - v;
         e1  = err_last[ch];
         e2  = err_older[ch];
         g0  = gain_now_q;
         g1  = gain_prev_q;
         g2  = gain_prev2_q;
         acc = drive_mem[ch];
         acc = acc + g0 * e0 + g1 * e1 + g2 * e2;
         drive_mem[ch]  = 40'(clamp_drive(acc));
         err_older[ch]  = err_last[ch];
         err_last[ch]   = ERR_W'(e0);
      end
      r.channel  = ch;
      r.dac_code = code_of(drive_mem[ch]);
      dac_expect_q.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gain_now_q   = '0;
         gain_prev_q  = '0;
         gain_prev2_q = '0;
         out_limit_q  = 15'd32767;
         tgt_limit_q  = 15'd32767;
         dac_zero_q   = 16'd32768;
         open_loop_q  = 1'b0;
         ol_gain_q    = 24'd65536;
         for (int i = 0; i < NUM_CH; i++) begin
            target_mem[i] = '0;
            err_last[i]   = '0;
            err_older[i]  = '0;
            drive_mem[i]  = '0;
         end
         dac_expect_q.delete();
      end else begin
         // compare before predicting: nothing leaves in the cycle it arrives
         if (rsp_valid && !rsp_stall) begin
            if (dac_expect_q.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_dac_code, -1);
            end else begin
               oldest = dac_expect_q.pop_front();
               results_checked++;
               if (rsp_target_rejected === 1'b1) rejects_seen++;
               if (rsp_channel_res !== oldest.channel)
                  report_mismatch("channel_res", rsp_channel_res, oldest.channel);
               if (rsp_dac_code !== oldest.dac_code)
                  report_mismatch("dac_code", rsp_dac_code, oldest.dac_code);
               if (rsp_target_rejected !== oldest.rejected)
                  report_mismatch("target_rejected", rsp_target_rejected, oldest.rejected);
            end
         end
         if (req_valid && !req_stall)
            predict_pid_step(req_action, req_channel, req_value);
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_GAIN_NOW:       gain_now_q   = csr_data[GAIN_W-1:0];
               CSR_GAIN_PREV:      gain_prev_q  = csr_data[GAIN_W-1:0];
               CSR_GAIN_PREV2:     gain_prev2_q = csr_data[GAIN_W-1:0];
               CSR_OUTPUT_LIMIT:   out_limit_q  = csr_data[LIMIT_W-1:0];
               CSR_TARGET_LIMIT:   tgt_limit_q  = csr_data[LIMIT_W-1:0];
               CSR_DAC_ZERO:       dac_zero_q   = csr_data[DAC_W-1:0];
               CSR_OPEN_LOOP:      open_loop_q  = csr_data[0];
               CSR_OPEN_LOOP_GAIN: ol_gain_q    = csr_data[OLG_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count <= dac_expect_q.size();
   end

endmodule

// ----- tb/multichannel_incremental_pid_tb.sv -----
module multichannel_incremental_pid_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mipid_pkg::*;
   import mipid_tb_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_action;
   logic [CHAN_W-1:0]         req_channel;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [CHAN_W-1:0]         rsp_channel_res;
   logic [DAC_W-1:0]          rsp_dac_code;
   logic                      rsp_target_rejected;
   logic                      csr_write;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;

   int mismatch_count, pending_count, results_checked, rejects_seen;

   // stimulus bookkeeping; used only to steer the stimulus and for the summary
   int                        idle_pct  = 0;
   int                        stall_pct = 0;
   int                        cur_tlim  = 32767;
   int                        targets_sent = 0;
   int                        samples_sent = 0;
   int                        settings_applied = 0;
   logic signed [VALUE_W-1:0] steer_target [NUM_CH];

   multichannel_incremental_pid #(.CHANNELS(NUM_CH)) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_channel         (req_channel),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_channel_res     (rsp_channel_res),
      .rsp_dac_code        (rsp_dac_code),
      .rsp_target_rejected (rsp_target_rejected),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // Checker sits beside the block: it watches both channels and the register
   // port, predicts every result and counts mismatches.
   mipid_checker u_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_channel         (req_channel),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_channel_res     (rsp_channel_res),
      .rsp_dac_code        (rsp_dac_code),
      .rsp_target_rejected (rsp_target_rejected),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count),
      .results_checked     (results_checked),
      .rejects_seen        (rejects_seen)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run of about 600 items.
   initial begin
      #1_000_000;
      $display("multichannel_incremental_pid_tb: done, errors");
      $finish;
   end

   // Receiver back-pressure: redraw the stall every cycle at the current rate.
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   // Select one of the four idling patterns. The stall rate goes through a
   // nonblocking write so the stall process always sees a settled value.
   task automatic set_idling(input int mode);
      case (mode)
         0: begin idle_pct = 0;  stall_pct <= 0;  end
         1: begin idle_pct = 62; stall_pct <= 0;  end
         2: begin idle_pct = 0;  stall_pct <= 62; end
         default: begin idle_pct = 12; stall_pct <= 12; end
      endcase
   endtask

   // Offer one item and hold it until the transfer happens. Random gaps go in
   // front; the payload is never changed while stalled.
   task automatic send_item(input action_type act, input int ch, input logic [15:0] v);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_channel <= ch[CHAN_W-1:0];
      req_value   <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (act == ACT_TARGET) targets_sent++;
      else samples_sent++;
   endtask

   // Drop valid and wait for every predicted result to come back. The first
   // edge lets the checker's count catch up with the last transfer.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] d);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
   endtask

   // Write the full register set; called only with the block idle.
   task automatic apply_settings(input logic [31:0] g0, input logic [31:0] g1,
                                 input logic [31:0] g2, input int olim, input int tlim,
                                 input int zero, input int ol, input int olg);
      write_reg(CSR_GAIN_NOW,       g0);
      write_reg(CSR_GAIN_PREV,      g1);
      write_reg(CSR_GAIN_PREV2,     g2);
      write_reg(CSR_OUTPUT_LIMIT,   olim);
      write_reg(CSR_TARGET_LIMIT,   tlim);
      write_reg(CSR_DAC_ZERO,       zero);
      write_reg(CSR_OPEN_LOOP,      ol);
      write_reg(CSR_OPEN_LOOP_GAIN, olg);
      csr_write <= 1'b0;
      cur_tlim = tlim;
      settings_applied++;
   endtask

   // Settle between phases: drain, then give the pipeline its latency again.
   task automatic quiesce();
      wait_drained();
      repeat (8) @(posedge clock);
   endtask

   // Gain of up to +/-2.0 in Q16.16, so loops move without pinning the clamp
   function automatic logic [31:0] modest_gain();
      return $urandom_range(0, 1 << 18) - (1 << 17);
   endfunction

   // One random item. Most samples sit close to the channel's target so the
   // loop actually regulates; the rest are full-range noise and extremes.
   task automatic random_item(output action_type act, output int ch, output logic [15:0] v);
      int pick;
      ch   = $urandom_range(0, NUM_CH - 1);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 30) begin
         act = ACT_TARGET;
         if (pick < 70) begin
            v = 16'($urandom_range(0, 2 * cur_tlim) - cur_tlim);
            steer_target[ch] = v;
         end else if (pick < 85) begin
            v = 16'($urandom);
         end else begin
            case ($urandom_range(0, 5))
               0: v = 16'sh8000;
               1: v = 16'sh7fff;
               2: v = 16'(cur_tlim);
               3: v = 16'(-cur_tlim);
               4: v = 16'(cur_tlim + 1);
               default: v = '0;
            endcase
         end
      end else begin
         act = ACT_SAMPLE;
         if (pick < 60) begin
            v = 16'(steer_target[ch] + $urandom_range(0, 64) - 32);
         end else if (pick < 90) begin
            v = 16'($urandom);
         end else begin
            case ($urandom_range(0, 3))
               0: v = 16'sh8000;
               1: v = 16'sh7fff;
               2: v = '1;
               default: v = '0;
            endcase
         end
      end
   endtask

   task automatic run_random_phase(input int n, input int mode, input bit pause_midway);
      action_type act;
      int         ch;
      logic [15:0] v;
      set_idling(mode);
      for (int i = 0; i < n; i++) begin
         // hold the sender off until the block has emptied completely
         if (pause_midway && i == n / 2) wait_drained();
         random_item(act, ch, v);
         send_item(act, ch, v);
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_CH; i++) steer_target[i] = '0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_action  <= ACT_SAMPLE;
      req_channel <= '0;
      req_value   <= '0;
      csr_write   <= 1'b0;
      csr_index   <= CSR_GAIN_NOW;
      csr_data    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed, closed loop: target at the limit on both signs and just past it
      // below zero, then samples at the value extremes to drive both clamps.
      set_idling(0);
      apply_settings(32'h0001_0000, 32'hffff_8000, 32'h0000_4000,
                     1000, 20000, 32768, 0, 65536);
      send_item(ACT_TARGET, 0, 20000);
      send_item(ACT_TARGET, 1, -20001);
      send_item(ACT_TARGET, 2, 32767);
      send_item(ACT_TARGET, 3, -32768);
      send_item(ACT_TARGET, 4, -20000);
      send_item(ACT_SAMPLE, 0, -32768);
      send_item(ACT_SAMPLE, 0, 32767);
      send_item(ACT_SAMPLE, 0, 0);
      send_item(ACT_SAMPLE, 4, 32767);
      send_item(ACT_SAMPLE, 7, -1);
      send_item(ACT_SAMPLE, 7, 0);

      // Directed, open loop with zero-code at 0 and the largest scale factor:
      // negative-zero guard lifts the drive to one count; samples only hold.
      quiesce();
      apply_settings(32'h0, 32'h0, 32'h0, 32767, 32767, 0, 1, 24'hff_ffff);
      send_item(ACT_TARGET, 4, -32768);
      send_item(ACT_TARGET, 5, 32767);
      send_item(ACT_SAMPLE, 5, -5);
      send_item(ACT_TARGET, 6, 0);
      send_item(ACT_TARGET, 1, 1);

      // Directed, zero limits, top zero-code and the extreme gains
      quiesce();
      apply_settings(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 65535, 0, 0);
      send_item(ACT_TARGET, 1, 0);
      send_item(ACT_TARGET, 1, 1);
      send_item(ACT_TARGET, 2, -1);
      send_item(ACT_SAMPLE, 1, -32768);
      send_item(ACT_SAMPLE, 1, 32767);
      send_item(ACT_SAMPLE, 3, 0);
      for (int i = 0; i < NUM_CH; i++) steer_target[i] = '0;

      // Random phases: each gets a fresh register set and an idling pattern.
      quiesce();
      apply_settings(modest_gain(), modest_gain(), modest_gain(), $urandom_range(0, 32767),
                     $urandom_range(0, 32767), $urandom_range(0, 65535), 0,
                     $urandom_range(0, 24'hff_ffff));
      run_random_phase(100, 0, 1'b0);

      quiesce();
      apply_settings(modest_gain(), modest_gain(), modest_gain(), $urandom_range(0, 32767),
                     $urandom_range(0, 32767), $urandom_range(0, 65535), 0, 65536);
      run_random_phase(100, 1, 1'b0);

      quiesce();
      apply_settings(32'h7fff_ffff, 32'h8000_0000, modest_gain(),
                     32767, 32767, 65535, 0, 24'hff_ffff);
      run_random_phase(80, 2, 1'b0);

      quiesce();
      apply_settings(modest_gain(), modest_gain(), modest_gain(), $urandom_range(0, 32767),
                     $urandom_range(0, 32767), $urandom_range(0, 65535), 1,
                     $urandom_range(0, 24'hff_ffff));
      run_random_phase(80, 3, 1'b0);

      quiesce();
      apply_settings($urandom, $urandom, $urandom, $urandom_range(0, 32767),
                     $urandom_range(0, 32767), 0, 0, $urandom_range(0, 24'hff_ffff));
      run_random_phase(80, 0, 1'b0);

      // small zero-code: the guard bites on the negative side
      quiesce();
      apply_settings(modest_gain(), modest_gain(), modest_gain(), 32767,
                     $urandom_range(0, 32767), $urandom_range(0, 8), 0, 0);
      run_random_phase(80, 1, 1'b0);

      quiesce();
      apply_settings(modest_gain(), modest_gain(), modest_gain(), $urandom_range(0, 32767),
                     $urandom_range(0, 32767), $urandom_range(0, 65535), 0,
                     $urandom_range(0, 24'hff_ffff));
      run_random_phase(80, 2, 1'b1);

      // Drain and let the pipeline run out before the verdict.
      wait_drained();
      repeat (10) @(posedge clock);

      $display("covered %0d set-target and %0d sample transfers over %0d register sets",
               targets_sent, samples_sent, settings_applied);
      $display("compared %0d results (%0d rejected targets), %0d mismatches",
               results_checked, rejects_seen, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("multichannel_incremental_pid_tb: done, clean");
      end else begin
         $display("multichannel_incremental_pid_tb: done, errors");
      end
      $finish;
   end

endmodule
